@@ sv/sv39_ptw_pkg.sv @@
// Package for the Sv39 page-table walker: operation codes, status codes,
// register indexes, PTE bit positions and the controller state type.
// No dependencies.
package sv39_ptw_pkg;

	// operation codes of an input beat
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_XLATE  = 2'd1;
	localparam logic [1:0] OP_USER   = 2'd2;

	// status codes of a result beat
	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_VA_HIGH   = 3'd1;
	localparam logic [2:0] STS_INVALID   = 3'd2;
	localparam logic [2:0] STS_NOT_USER  = 3'd3;
	localparam logic [2:0] STS_OUTSIDE   = 3'd4;

	// configuration register indexes
	localparam logic REG_ROOT_TABLE_PAGE = 1'b0;
	localparam logic REG_STORE_BASE_PAGE = 1'b1;

	// PTE layout
	localparam int PTE_V_BIT   = 0;
	localparam int PTE_U_BIT   = 4;
	localparam int PTE_PPN_LSB = 10;
	localparam int PPN_W       = 44;
	localparam int PA_W        = 56;
	localparam int VA_W        = 39;
	localparam int IDX_W       = 9;
	localparam int OFS_W       = 12;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_RESP
	} ptw_state_t;

endpackage

@@ sv/sv39_page_table_walker_unit.sv @@
// Sv39 page-table walker top level: PTE store in one synchronous RAM,
// walk controller and result register. Depends on sv39_ptw_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per item: a table
//   word write (operation 0), a translation returning page plus offset
//   (operation 1) or a user page lookup returning the page base (operation 2).
//   Output channel (out_valid / out_stall) returns exactly one beat per item:
//   physical_address and status.
//   Configuration: cfg_write with cfg_index 0 sets the root table page,
//   index 1 sets the physical page of the first store page. Write only idle.
// Flow:
//   A write, an out-of-range VA or a root outside the store: result visible
//   in the cycle after acceptance; the next item is accepted right after
//   unless out_stall holds the result. A full walk: three dependent reads of
//   the single-port RAM, one per cycle, the range check of each next table
//   folded into the cycle that uses the returned PTE; no new item is accepted
//   until the walk result has left the walk. A walk that ends early (invalid
//   entry, pointer outside the store) finishes after the level that stopped it.
// Reset:
//   Control and configuration registers clear at once, then all
//   TABLE_PAGES*512 RAM words are zeroed one word per cycle; in_stall stays
//   high during that sweep while configuration writes are still taken.
// Back-pressure:
//   The result register holds while out_stall is high; the next item is
//   accepted only when its result can move into that register, otherwise a
//   finished walk parks its result until the register frees.
module sv39_page_table_walker_unit #(
	parameter int TABLE_PAGES   = 8,
	parameter int VA_LIMIT_BITS = 38
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_write,
	input  logic                                cfg_index,
	input  logic [sv39_ptw_pkg::PPN_W-1:0]      cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          operation,
	input  logic [11:0]                         table_word_index,
	input  logic [63:0]                         table_word,
	input  logic [sv39_ptw_pkg::VA_W-1:0]       virtual_address,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sv39_ptw_pkg::PA_W-1:0]       physical_address,
	output logic [2:0]                          status
);
	import sv39_ptw_pkg::*;

	localparam int STORE_WORDS = TABLE_PAGES * 512;
	localparam int AW          = $clog2(TABLE_PAGES) + IDX_W;

	// configuration registers
	logic [PPN_W-1:0] root_table_page_q;
	logic [PPN_W-1:0] store_base_page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_table_page_q <= '0;
			store_base_page_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROOT_TABLE_PAGE: root_table_page_q <= cfg_data;
				REG_STORE_BASE_PAGE: store_base_page_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control and walk registers
	ptw_state_t       state_q, state_d;
	logic [AW-1:0]    clr_cnt_q;
	logic [1:0]       lvl_q, lvl_d;
	logic [1:0]       op_q;
	logic [VA_W-1:0]  va_q;
	logic             out_valid_q;
	logic [PA_W-1:0]  pa_q;
	logic [2:0]       status_q;
	logic [PA_W-1:0]  park_pa_q;
	logic [2:0]       park_status_q;

	// RAM port
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_addr;
	logic [63:0]      mem_wdata;
	logic [63:0]      rd_data_q;
	logic [63:0]      mem_q [STORE_WORDS];

	// combinational helpers
	logic             accept;
	logic             out_free;
	logic [PPN_W-1:0] chk_page;
	logic [PPN_W-1:0] chk_rel;
	logic             chk_inside;
	logic [IDX_W-1:0] nxt_idx;
	logic [PPN_W-1:0] pte_ppn;
	logic             va_high;
	logic             res_load;
	logic             park_load;
	logic [PA_W-1:0]  res_pa;
	logic [2:0]       res_status;
	logic             walk_start;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == S_IDLE) && out_free);
	assign accept   = in_valid && !in_stall;
	assign pte_ppn  = rd_data_q[PTE_PPN_LSB +: PPN_W];
	assign va_high  = ((40'(virtual_address) >> VA_LIMIT_BITS) != 40'd0);

	// store range check of the next table page: root at accept, PTE pointer in walk
	assign chk_page   = (state_q == S_IDLE) ? root_table_page_q : pte_ppn;
	assign chk_rel    = chk_page - store_base_page_q;
	assign chk_inside = (chk_page >= store_base_page_q) && (chk_rel < PPN_W'(TABLE_PAGES));

	// VA index of the level to read next
	always_comb begin
		case (lvl_q)
			2'd2:    nxt_idx = va_q[29:21];
			default: nxt_idx = va_q[20:12];
		endcase
	end

	// next state, RAM control and result
	always_comb begin
		state_d    = state_q;
		lvl_d      = lvl_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_addr   = clr_cnt_q;
		mem_wdata  = '0;
		res_load   = 1'b0;
		park_load  = 1'b0;
		res_pa     = '0;
		res_status = STS_OK;
		walk_start = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				if (clr_cnt_q == AW'(STORE_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (operation)
						OP_WRITE: begin
							res_load = 1'b1;
							if (32'(table_word_index) < STORE_WORDS) begin
								mem_we    = 1'b1;
								mem_addr  = AW'(table_word_index);
								mem_wdata = table_word;
							end else begin
								res_status = STS_OUTSIDE;
							end
						end
						OP_XLATE, OP_USER: begin
							if (va_high) begin
								res_load   = 1'b1;
								res_status = STS_VA_HIGH;
							end else if (!chk_inside) begin
								res_load   = 1'b1;
								res_status = STS_OUTSIDE;
							end else begin
								mem_re     = 1'b1;
								mem_addr   = AW'({chk_rel, virtual_address[38:30]});
								walk_start = 1'b1;
								lvl_d      = 2'd2;
								state_d    = S_WALK;
							end
						end
						default: res_load = 1'b1;
					endcase
				end
			end
			S_WALK: begin
				if (!rd_data_q[PTE_V_BIT]) begin
					res_status = STS_INVALID;
					park_load  = 1'b1;
				end else if (lvl_q == 2'd0) begin
					park_load = 1'b1;
					if (op_q == OP_USER) begin
						if (rd_data_q[PTE_U_BIT]) begin
							res_pa = {pte_ppn, OFS_W'(0)};
						end else begin
							res_status = STS_NOT_USER;
						end
					end else begin
						res_pa = {pte_ppn, va_q[OFS_W-1:0]};
					end
				end else if (!chk_inside) begin
					res_status = STS_OUTSIDE;
					park_load  = 1'b1;
				end else begin
					mem_re   = 1'b1;
					mem_addr = AW'({chk_rel, nxt_idx});
					lvl_d    = lvl_q - 2'd1;
				end
				// hand the result over now if the output register is free
				if (park_load) begin
					if (out_free) begin
						res_load  = 1'b1;
						park_load = 1'b0;
						state_d   = S_IDLE;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_RESP: begin
				res_pa     = park_pa_q;
				res_status = park_status_q;
				if (out_free) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			lvl_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (walk_start) begin
			op_q <= operation;
			va_q <= virtual_address;
		end
		if (res_load) begin
			pa_q     <= res_pa;
			status_q <= res_status;
		end
		if (park_load) begin
			park_pa_q     <= res_pa;
			park_status_q <= res_status;
		end
	end

	// PTE store: one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_addr];
		end
	end

	assign out_valid        = out_valid_q;
	assign physical_address = pa_q;
	assign status           = status_q;

`ifndef SYNTH
	// no item taken while the store is being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> in_stall)
		else $error("item accepted during store clear");

	// a failing status never carries an address
	a_err_pa_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != STS_OK)) |-> (physical_address == '0))
		else $error("nonzero address with error status");

	// a started walk begins at the root level
	a_walk_starts_root: assert property (@(posedge clk) disable iff (!arst_n)
		walk_start |=> ((state_q == S_WALK) && (lvl_q == 2'd2)))
		else $error("walk did not start at level 2");

	// reads only while walking or at the accept that starts a walk
	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (walk_start || (state_q == S_WALK)))
		else $error("store read outside a walk");

	// a parked result is only produced when the output register is busy
	a_park_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP) |-> $past(out_valid_q && out_stall))
		else $error("result parked while output register was free");
`endif

endmodule
